// ----- rtl/ldg_pkg.sv -----
package ldg_pkg;

    // Lattice geometry
    localparam int GRID_SIDE = 64;
    localparam int COORD_W   = $clog2(GRID_SIDE);
    localparam int SIDE_W    = COORD_W + 1;
    localparam int ROW_W     = 2 * COORD_W;
    localparam int ROWS      = GRID_SIDE * GRID_SIDE;

    // Field widths
    localparam int OP_W       = 3;
    localparam int AXIS_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int CNT_W      = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    // Remainder unit: one quotient bit per cycle
    localparam int MOD_W     = 2 * SIDE_W - 1;
    localparam int MOD_CNT_W = $clog2(SIDE_W);

    // Box radii: floor(side * pct / 100) as a reciprocal multiply
    localparam int RADIUS_SHIFT = 19;
    localparam int MULT_W       = RADIUS_SHIFT;
    localparam int PROD_W       = SIDE_W + MULT_W;
    localparam int BIRTH_MULT   = (45 * (2 ** RADIUS_SHIFT)) / 100 + 1;
    localparam int DEATH_MULT   = (49 * (2 ** RADIUS_SHIFT)) / 100 + 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_CENTRE = 3'd0,
        OP_SEED   = 3'd1,
        OP_LAUNCH = 3'd2,
        OP_STEP   = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED    = 3'd0,
        ST_OCCUPIED  = 3'd1,
        ST_OUTSIDE   = 3'd2,
        ST_MOVED     = 3'd3,
        ST_STUCK     = 3'd4,
        ST_DIED      = 3'd5,
        ST_NO_WALKER = 3'd6,
        ST_READ_DONE = 3'd7
    } status_t;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE_X = 2'd0,
        REG_SIDE_Y = 2'd1,
        REG_SIDE_Z = 2'd2,
        REG_TARGET = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_EVAL
    } state_t;

    typedef struct packed {
        logic [SIDE_W-1:0]  side;
        logic [COORD_W-1:0] half;
        logic [COORD_W-1:0] seed_off;
        logic [SIDE_W-1:0]  blo;
        logic [SIDE_W-1:0]  bhi;
        logic [SIDE_W-1:0]  dlo;
        logic [SIDE_W-1:0]  dhi;
    } axis_cfg_t;

    typedef struct packed {
        axis_cfg_t [2:0]    axis;
        logic [CNT_W-1:0]   target;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [AXIS_W-1:0]  step_axis;
        logic               step_up;
    } item_t;

    typedef struct packed {
        logic                 clr_step;
        logic                 accept;
        logic                 mod_step;
        logic [MOD_CNT_W-1:0] mod_bit;
        logic                 rd_issue;
        logic                 eval;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic seed_op;
        logic out_free;
    } dp_stat_t;

    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] raw);
        logic [SIDE_W-1:0] s;
        s = raw;
        if (raw == '0)
            s = SIDE_W'(1);
        else if (raw > SIDE_W'(GRID_SIDE))
            s = SIDE_W'(GRID_SIDE);
        return s;
    endfunction

    function automatic logic [COORD_W-1:0] box_radius(input logic [SIDE_W-1:0] s,
                                                      input int mult);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(s) * PROD_W'(mult);
        return prod[RADIUS_SHIFT +: COORD_W];
    endfunction

    function automatic axis_cfg_t axis_setup(input logic [SIDE_W-1:0] raw);
        axis_cfg_t          c;
        logic [SIDE_W-1:0]  s;
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] rb;
        logic [COORD_W-1:0] rd;
        s  = eff_side(raw);
        h  = s[SIDE_W-1:1];
        rb = box_radius(s, BIRTH_MULT);
        rd = box_radius(s, DEATH_MULT);
        c.side     = s;
        c.half     = h;
        c.seed_off = h - rb;
        if (s == SIDE_W'(1)) begin
            // single-cell axis: box test passes for the only on-grid coordinate
            c.blo = '0;
            c.bhi = SIDE_W'(1);
            c.dlo = '0;
            c.dhi = SIDE_W'(1);
        end else begin
            c.blo = {1'b0, h} - {1'b0, rb};
            c.bhi = {1'b0, h} + {1'b0, rb};
            c.dlo = {1'b0, h} - {1'b0, rd};
            c.dhi = {1'b0, h} + {1'b0, rd};
        end
        return c;
    endfunction

    localparam axis_cfg_t AXIS_RESET = axis_setup(SIDE_W'(GRID_SIDE));

endpackage

// ----- rtl/ldg_if.sv -----
interface ldg_item_if;
    import ldg_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic [AXIS_W-1:0]  step_axis;
    logic               step_up;

    modport source (output valid, op, pos_x, pos_y, pos_z, step_axis, step_up,
                    input ready);
    modport sink (input valid, op, pos_x, pos_y, pos_z, step_axis, step_up,
                  output ready);
endinterface

interface ldg_result_if;
    import ldg_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                cell_full;
    logic                walker_live;
    logic [COORD_W-1:0]  walker_x;
    logic [COORD_W-1:0]  walker_y;
    logic [COORD_W-1:0]  walker_z;
    logic [CNT_W-1:0]    cells_placed;
    logic                done_res;

    modport source (output valid, status, cell_full, walker_live, walker_x, walker_y,
                    walker_z, cells_placed, done_res, input ready);
    modport sink (input valid, status, cell_full, walker_live, walker_x, walker_y,
                  walker_z, cells_placed, done_res, output ready);
endinterface

interface ldg_cfg_if;
    import ldg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/ldg_ram.sv -----
module ldg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [WIDTH-1:0]         wmask,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // bit-masked write, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- rtl/ldg_cfg.sv -----
module ldg_cfg (
    input  logic          clk,
    input  logic          rst_n,
    ldg_cfg_if.sink       cfg,
    output ldg_pkg::cfg_t regs
);
    import ldg_pkg::*;

    axis_cfg_t [2:0]  axis_reg;
    logic [CNT_W-1:0] target_reg;

    assign cfg.ready = 1'b1;

    // box bounds are worked out once, when the side is written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg   <= {3{AXIS_RESET}};
            target_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_SIDE_X: axis_reg[0] <= axis_setup(cfg.data[SIDE_W-1:0]);
                REG_SIDE_Y: axis_reg[1] <= axis_setup(cfg.data[SIDE_W-1:0]);
                REG_SIDE_Z: axis_reg[2] <= axis_setup(cfg.data[SIDE_W-1:0]);
                REG_TARGET: target_reg  <= cfg.data[CNT_W-1:0];
                default:    target_reg  <= target_reg;
            endcase
        end
    end

    assign regs.axis   = axis_reg;
    assign regs.target = target_reg;

endmodule

// ----- rtl/ldg_ctrl.sv -----
module ldg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ldg_pkg::dp_stat_t stat,
    output ldg_pkg::dp_cmd_t  cmd
);
    import ldg_pkg::*;

    localparam logic [MOD_CNT_W-1:0] MOD_TOP = MOD_CNT_W'(SIDE_W - 1);

    state_t               state_reg;
    state_t               state_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            mod_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mod_cnt_reg <= mod_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mod_cnt_next = mod_cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mod_bit  = mod_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.seed_op)
                    begin
                        state_next   = S_MOD;
                        mod_cnt_next = MOD_TOP;
                    end
                    else
                        state_next = S_EVAL;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (mod_cnt_reg == '0)
                    state_next = S_READ;
                else
                    mod_cnt_next = mod_cnt_reg - MOD_CNT_W'(1);
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.out_free)
                begin
                    cmd.eval   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/ldg_dp.sv -----
module ldg_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ldg_pkg::cfg_t     regs,
    input  ldg_pkg::item_t    item_data,
    input  ldg_pkg::dp_cmd_t  cmd,
    output ldg_pkg::dp_stat_t stat,
    ldg_result_if.source      result
);
    import ldg_pkg::*;

    // item position; holds the running remainder during a random seed
    logic [2:0][SIDE_W-1:0]  pos_reg;
    logic [2:0][SIDE_W-1:0]  pos_next;
    logic [2:0][SIDE_W-1:0]  pos_in;
    logic [2:0][SIDE_W-1:0]  step_pos;
    logic [2:0][COORD_W-1:0] item_pos;
    logic [OP_W-1:0]         op_reg;

    logic [2:0][COORD_W-1:0] walker_reg;
    logic [2:0][COORD_W-1:0] walker_next;
    logic                    live_reg;
    logic                    live_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic                    full_reg;
    logic                    full_next;
    logic [ROW_W-1:0]        clr_cnt_reg;

    logic [2:0]              axis_sel;
    logic [MOD_W-1:0]        sub_val [3];

    logic                    ram_we;
    logic [ROW_W-1:0]        ram_waddr;
    logic [GRID_SIDE-1:0]    ram_wdata;
    logic [GRID_SIDE-1:0]    ram_wmask;
    logic                    ram_re;
    logic [ROW_W-1:0]        ram_raddr_a;
    logic [GRID_SIDE-1:0]    rdata_a;
    logic [GRID_SIDE-1:0]    rdata_b;
    logic [GRID_SIDE-1:0]    bit_onehot;

    logic                    hit_a;
    logic                    hit_b;
    logic                    on_grid;
    logic                    in_birth;
    logic                    in_death;
    logic                    wr_pos;
    logic                    wr_walker;
    logic                    count_inc;

    assign item_pos[0] = item_data.pos_x;
    assign item_pos[1] = item_data.pos_y;
    assign item_pos[2] = item_data.pos_z;

    always_comb
    begin
        case (axis_t'(item_data.step_axis))
            AXIS_X:  axis_sel = 3'b001;
            AXIS_Y:  axis_sel = 3'b010;
            default: axis_sel = 3'b100;
        endcase
    end

    // position taken at accept; a step below zero wraps high and fails the side test
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            step_pos[a] = {1'b0, walker_reg[a]};
            if (axis_sel[a])
                step_pos[a] = item_data.step_up ? step_pos[a] + SIDE_W'(1)
                                                : step_pos[a] - SIDE_W'(1);
            case (op_t'(item_data.op))
                OP_CENTRE: pos_in[a] = {1'b0, regs.axis[a].half};
                OP_SEED:   pos_in[a] = {1'b0, regs.axis[a].seed_off} + {1'b0, item_pos[a]};
                OP_STEP:   pos_in[a] = step_pos[a];
                default:   pos_in[a] = {1'b0, item_pos[a]};
            endcase
        end
    end

    // restoring remainder, one bit per cycle on all axes
    always_comb
    begin
        pos_next = pos_reg;
        for (int a = 0; a < 3; a++)
        begin
            sub_val[a] = MOD_W'(regs.axis[a].side) << cmd.mod_bit;
            if (cmd.accept)
                pos_next[a] = pos_in[a];
            else if (cmd.mod_step && (MOD_W'(pos_reg[a]) >= sub_val[a]))
                pos_next[a] = pos_reg[a] - sub_val[a][SIDE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.accept)
            op_reg <= item_data.op;
    end

    // lattice: one row per (x, y), bit z within the row
    assign ram_re      = cmd.accept || cmd.rd_issue;
    assign ram_raddr_a = cmd.accept ? {pos_in[0][COORD_W-1:0], pos_in[1][COORD_W-1:0]}
                                    : {pos_reg[0][COORD_W-1:0], pos_reg[1][COORD_W-1:0]};

    ldg_ram #(
        .WIDTH (GRID_SIDE),
        .DEPTH (ROWS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .wmask   (ram_wmask),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b ({walker_reg[0], walker_reg[1]}),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign hit_a = rdata_a[pos_reg[2][COORD_W-1:0]];
    assign hit_b = rdata_b[walker_reg[2]];

    always_comb
    begin
        on_grid  = 1'b1;
        in_birth = 1'b1;
        in_death = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (pos_reg[a] >= regs.axis[a].side)
                on_grid = 1'b0;
            if ((pos_reg[a] < regs.axis[a].blo) || (pos_reg[a] >= regs.axis[a].bhi))
                in_birth = 1'b0;
            if ((pos_reg[a] < regs.axis[a].dlo) || (pos_reg[a] >= regs.axis[a].dhi))
                in_death = 1'b0;
        end
    end

    always_comb
    begin
        status_next = ST_READ_DONE;
        full_next   = 1'b0;
        walker_next = walker_reg;
        live_next   = live_reg;
        wr_pos      = 1'b0;
        wr_walker   = 1'b0;
        count_inc   = 1'b0;
        case (op_t'(op_reg))
            OP_CENTRE, OP_SEED:
            begin
                full_next = 1'b1;
                if (hit_a)
                    status_next = ST_OCCUPIED;
                else
                begin
                    status_next = ST_PLACED;
                    wr_pos      = 1'b1;
                    count_inc   = 1'b1;
                end
            end
            OP_LAUNCH:
            begin
                if (!(on_grid && in_birth))
                    status_next = ST_OUTSIDE;
                else if (hit_a)
                begin
                    status_next = ST_OCCUPIED;
                    full_next   = 1'b1;
                end
                else
                begin
                    status_next = ST_PLACED;
                    live_next   = 1'b1;
                    for (int a = 0; a < 3; a++)
                        walker_next[a] = pos_reg[a][COORD_W-1:0];
                end
            end
            OP_STEP:
            begin
                if (!live_reg)
                    status_next = ST_NO_WALKER;
                else if (!(on_grid && in_death))
                begin
                    status_next = ST_DIED;
                    live_next   = 1'b0;
                end
                else if (hit_a)
                begin
                    // stick on the cell the walker came from
                    status_next = ST_STUCK;
                    full_next   = 1'b1;
                    live_next   = 1'b0;
                    wr_walker   = 1'b1;
                    count_inc   = !hit_b;
                end
                else
                begin
                    status_next = ST_MOVED;
                    for (int a = 0; a < 3; a++)
                        walker_next[a] = pos_reg[a][COORD_W-1:0];
                end
            end
            default:
            begin
                status_next = ST_READ_DONE;
                full_next   = on_grid && hit_a;
            end
        endcase
    end

    assign count_next = (count_inc && (count_reg != COUNT_MAX)) ? count_reg + CNT_W'(1)
                                                               : count_reg;

    assign bit_onehot = wr_walker ? (GRID_SIDE'(1) << walker_reg[2])
                                  : (GRID_SIDE'(1) << pos_reg[2][COORD_W-1:0]);

    always_comb
    begin
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
            ram_wmask = '1;
        end
        else
        begin
            ram_we    = cmd.eval && (wr_pos || wr_walker);
            ram_waddr = wr_walker ? {walker_reg[0], walker_reg[1]}
                                  : {pos_reg[0][COORD_W-1:0], pos_reg[1][COORD_W-1:0]};
            ram_wdata = bit_onehot;
            ram_wmask = bit_onehot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            walker_reg    <= '0;
            live_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
            if (cmd.eval)
            begin
                walker_reg    <= walker_next;
                live_reg      <= live_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            status_reg <= status_next;
            full_reg   <= full_next;
        end
    end

    assign stat.clr_last = (clr_cnt_reg == ROW_W'(ROWS - 1));
    assign stat.seed_op  = (item_data.op == OP_SEED);
    assign stat.out_free = !out_valid_reg || result.ready;

    // walker and count only change on the next eval, which waits for this slot
    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.cell_full    = full_reg;
    assign result.walker_live  = live_reg;
    assign result.walker_x     = walker_reg[0];
    assign result.walker_y     = walker_reg[1];
    assign result.walker_z     = walker_reg[2];
    assign result.cells_placed = count_reg;
    assign result.done_res     = (count_reg >= regs.target);

endmodule

// ----- rtl/lattice_dla_growth_step.sv -----
// Channel   Dir  Payload                                                   Transaction
// item      in   op, pos_x, pos_y, pos_z, step_axis, step_up               valid && ready
// result    out  status, cell_full, walker_live, walker_x/y/z,             valid && ready
//                cells_placed, done_res
// cfg       in   index (0 side_x, 1 side_y, 2 side_z, 3 target_cells),    valid && ready
//                data
//
// Sequence: accept with lattice read, then evaluate and write back; the next item
//   is taken only after that. A random seed inserts the bit-per-cycle remainder unit
//   (7 steps) and a second lattice read before evaluating.
// Reset: a clearing pass sweeps all 4096 rows of the lattice RAM one row per cycle;
//   item.ready stays low meanwhile, cfg is accepted throughout.
// Stalls: a finished result sits in the output register; the next item is
//   taken meanwhile and waits in its evaluate cycle until that slot frees.
module lattice_dla_growth_step (
    input  logic         clk,
    input  logic         rst_n,
    ldg_item_if.sink     item,
    ldg_result_if.source result,
    ldg_cfg_if.sink      cfg
);
    import ldg_pkg::*;

    cfg_t     cfg_regs;   // per-axis side and precomputed box bounds, target count
    item_t    item_data;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign item_data.op        = item.op;
    assign item_data.pos_x     = item.pos_x;
    assign item_data.pos_y     = item.pos_y;
    assign item_data.pos_z     = item.pos_z;
    assign item_data.step_axis = item.step_axis;
    assign item_data.step_up   = item.step_up;

    // Register file: box bounds are derived at write time so the datapath
    // only compares.
    ldg_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    // Sequencer: clear sweep, accept, remainder steps, read, evaluate.
    ldg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: walker state, placed count, occupancy RAM with one read port
    // for the addressed cell and one for the walker's own cell (stuck case),
    // and the output register.
    ldg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (cfg_regs),
        .item_data (item_data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule
